@@ rtl/core/rau_pkg.sv @@
// Package for the rational arithmetic unit: command codes, states, widths.
`default_nettype none
package rau_pkg;
    localparam int RauWidth = 32;
    localparam int OpW      = 32;
    localparam int WideW    = 64;

    localparam logic [3:0] CMD_NORM = 4'd0;
    localparam logic [3:0] CMD_ADD  = 4'd1;
    localparam logic [3:0] CMD_SUB  = 4'd2;
    localparam logic [3:0] CMD_MUL  = 4'd3;
    localparam logic [3:0] CMD_DIV  = 4'd4;
    localparam logic [3:0] CMD_CMP  = 4'd5;
    localparam logic [3:0] CMD_NEG  = 4'd6;
    localparam logic [3:0] CMD_INV  = 4'd7;
    localparam logic [3:0] CMD_ABS  = 4'd8;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DEN  = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_COMB, ST_GSTART, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
    } state_t;
endpackage
`default_nettype wire

@@ rtl/core/rational_arithmetic_unit_top.sv @@
// Top level of the rational arithmetic unit: sequencer and result register.
// A request is either rejected up front, or runs through setup and the products (for two
// operands), the binary GCD, two exact divisions by the GCD and issue; compare stops after
// the products. The unit takes one request at a time; s_tready is high only while the
// sequencer is idle. A finished result waits in the output register while the next one runs.
// Reset: synchronous active-low aresetn clears the sequencer and output valid.
`default_nettype none
module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int WIDTH = RauWidth
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // num_a, den_a, num_b, den_b
    input  wire logic [3:0]   s_tuser,  // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata   // num_out, den_out, less, equal, greater, error_code
);
    localparam int W = (WIDTH > 32) ? 32 : WIDTH;
    localparam logic [WideW-1:0] LIM = WideW'(1) << (W - 1);

    state_t state_reg, state_next;
    logic [3:0] cmd_reg;
    logic signed [OpW-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic signed [WideW-1:0] p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;
    logic [1:0] idx_reg, idx_next;
    logic [WideW-1:0] mag_reg, mag_next, d_reg, d_next, qn_reg, qn_next;
    logic neg_reg, neg_next;
    logic [1:0] err_reg, err_next;
    logic [2:0] flg_reg, flg_next;
    logic out_v_reg, out_v_next;
    logic [71:0] out_reg, out_next;
    logic signed [OpW-1:0] mul_a, mul_b;
    logic signed [WideW-1:0] mul_p, n_wide, d_wide;
    logic gcd_start, gcd_done, div_start, div_done;
    logic [WideW-1:0] g, quot, div_dividend, num_mag;
    logic signed [OpW-1:0] num_o;

    rau_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));

    rau_gcd u_gcd (
        .aclk(aclk), .aresetn(aresetn), .start(gcd_start),
        .a_in(mag_reg), .b_in(d_reg), .done(gcd_done), .g(g)
    );

    rau_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .divisor(g), .done(div_done), .quotient(quot)
    );

    assign div_dividend = (state_reg == ST_GCD) ? mag_reg : d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser;
            na_reg  <= s_tdata[31:0];
            da_reg  <= s_tdata[63:32];
            nb_reg  <= s_tdata[95:64];
            db_reg  <= s_tdata[127:96];
        end
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        idx_reg <= idx_next;
        mag_reg <= mag_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        qn_reg  <= qn_next;
        err_reg <= err_next;
        flg_reg <= flg_next;
        out_reg <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        idx_next = idx_reg;
        mag_next = mag_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        qn_next = qn_reg;
        err_next = err_reg;
        flg_next = flg_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        gcd_start = 1'b0;
        div_start = 1'b0;
        s_tready = (state_reg == ST_IDLE);
        n_wide = '0;
        d_wide = '0;
        num_mag = '0;
        num_o = '0;
        mul_a = na_reg;
        mul_b = db_reg;
        case (idx_reg)
            2'd0: begin
                mul_a = na_reg;
                mul_b = (cmd_reg == CMD_MUL) ? nb_reg : db_reg;
            end
            2'd1: begin
                mul_a = nb_reg;
                mul_b = da_reg;
            end
            default: begin
                mul_a = da_reg;
                mul_b = (cmd_reg == CMD_DIV) ? nb_reg : db_reg;
            end
        endcase

        if (m_tready) begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                err_next = ERR_NONE;
                flg_next = '0;
                idx_next = '0;
                n_wide = WideW'(na_reg);
                d_wide = WideW'(da_reg);
                state_next = ST_GSTART;
                if (cmd_reg > CMD_ABS) begin
                    err_next = ERR_DEN;
                    state_next = ST_DONE;
                end else if (cmd_reg == CMD_NORM) begin
                    if (da_reg == '0) begin
                        err_next = ERR_DEN;
                        state_next = ST_DONE;
                    end else if (da_reg < 0) begin
                        n_wide = -WideW'(na_reg);
                        d_wide = -WideW'(da_reg);
                    end
                end else if (da_reg <= 0) begin
                    err_next = ERR_DEN;
                    state_next = ST_DONE;
                end else if (cmd_reg <= CMD_CMP) begin
                    if (db_reg <= 0 || (cmd_reg == CMD_DIV && nb_reg == '0)) begin
                        err_next = ERR_DEN;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end else if (cmd_reg == CMD_NEG) begin
                    n_wide = -WideW'(na_reg);
                end else if (cmd_reg == CMD_INV) begin
                    if (na_reg == '0) begin
                        err_next = ERR_DEN;
                        state_next = ST_DONE;
                    end else if (na_reg < 0) begin
                        n_wide = -WideW'(da_reg);
                        d_wide = -WideW'(na_reg);
                    end else begin
                        n_wide = WideW'(da_reg);
                        d_wide = WideW'(na_reg);
                    end
                end else begin
                    n_wide = (na_reg < 0) ? -WideW'(na_reg) : WideW'(na_reg);
                end
                neg_next = n_wide[WideW-1];
                mag_next = n_wide[WideW-1] ? -n_wide : n_wide;
                d_next = d_wide;
            end
            ST_MUL: begin
                idx_next = idx_reg + 2'd1;
                case (idx_reg)
                    2'd1: p0_next = mul_p;
                    2'd2: p1_next = mul_p;
                    2'd3: p2_next = mul_p;
                    default: ;
                endcase
                if (idx_reg == 2'd3) begin
                    state_next = ST_COMB;
                end
            end
            ST_COMB: begin
                state_next = ST_GSTART;
                d_wide = p2_reg;
                case (cmd_reg)
                    CMD_ADD: n_wide = p0_reg + p1_reg;
                    CMD_SUB: n_wide = p0_reg - p1_reg;
                    CMD_MUL: n_wide = p0_reg;
                    CMD_DIV: begin
                        n_wide = (p2_reg < 0) ? -p0_reg : p0_reg;
                        d_wide = (p2_reg < 0) ? -p2_reg : p2_reg;
                    end
                    default: begin
                        flg_next = {p0_reg > p1_reg, p0_reg == p1_reg, p0_reg < p1_reg};
                        state_next = ST_DONE;
                    end
                endcase
                neg_next = n_wide[WideW-1];
                mag_next = n_wide[WideW-1] ? -n_wide : n_wide;
                d_next = d_wide;
            end
            ST_GSTART: begin
                gcd_start = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (gcd_done) begin
                    div_start = 1'b1;
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    qn_next = quot;
                    div_start = 1'b1;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    d_next = quot;
                    if ((neg_reg ? (qn_reg > LIM) : (qn_reg > LIM - 1)) || quot > LIM - 1) begin
                        err_next = ERR_OVF;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_v_reg || m_tready) begin
                    num_mag = neg_reg ? -qn_reg : qn_reg;
                    num_o = num_mag[OpW-1:0];
                    if (err_reg != ERR_NONE) begin
                        out_next = {4'd0, err_reg, 3'b000, 31'd1, 32'd0};
                    end else if (cmd_reg == CMD_CMP) begin
                        out_next = {4'd0, ERR_NONE, flg_reg, 31'd1, 32'd0};
                    end else begin
                        out_next = {4'd0, ERR_NONE, 3'b000, d_reg[30:0], num_o};
                    end
                    out_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:66] != ERR_NONE |-> m_tdata[62:0] == {31'd1, 32'd0})
        else $error("error result is not 0/1");
    a_den_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[62:32] != '0)
        else $error("zero denominator");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tdata[65:63]) <= 1)
        else $error("more than one compare flag");
    a_errcode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:66] != 2'd3)
        else $error("bad error code");
endmodule
`default_nettype wire

@@ rtl/core/rau_mul.sv @@
// Shared signed 32 by 32 multiplier with registered product.
`default_nettype none
module rau_mul
    import rau_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic signed [OpW-1:0]   a,
    input  wire logic signed [OpW-1:0]   b,
    output logic signed [WideW-1:0]      p
);
    logic signed [WideW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= WideW'(a) * WideW'(b);
    end

    assign p = p_reg;
endmodule
`default_nettype wire

@@ rtl/core/rau_gcd.sv @@
// Iterative binary GCD, one shift or subtract per cycle.
`default_nettype none
module rau_gcd
    import rau_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [WideW-1:0]   a_in,
    input  wire logic [WideW-1:0]   b_in,
    output logic                    done,
    output logic [WideW-1:0]        g
);
    logic [WideW-1:0] a_reg, a_next, b_reg, b_next, g_reg, g_next;
    logic [6:0]       k_reg, k_next;
    logic             busy_reg, busy_next, done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (a_reg == '0) begin
                g_next    = b_reg << k_reg[5:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!a_reg[0] && !b_reg[0]) begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 7'd1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg >= b_reg) begin
                a_next = a_reg - b_reg;
            end else begin
                b_next = b_reg - a_reg;
            end
        end
    end

    assign done = done_reg;
    assign g    = g_reg;
endmodule
`default_nettype wire

@@ rtl/core/rau_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rau_div
    import rau_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [WideW-1:0]   dividend,
    input  wire logic [WideW-1:0]   divisor,
    output logic                    done,
    output logic [WideW-1:0]        quotient
);
    logic [WideW:0]   rem_reg, rem_next, rem_sh, trial;
    logic [WideW-1:0] q_reg, q_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        rem_sh    = {rem_reg[WideW-1:0], q_reg[WideW-1]};
        trial     = rem_sh - {1'b0, divisor};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            q_next    = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[WideW]) begin
                rem_next = trial;
                q_next   = {q_reg[WideW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                q_next   = {q_reg[WideW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(WideW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the rational arithmetic unit: command mix, checks against a predictor.
module testbench
    import rau_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               lt;
        logic               eq;
        logic               gt;
        logic [1:0]         err;
    } frac_result_t;

    class frac_scoreboard;
        frac_result_t pending[$];
        int errors;
        int checked;

        function frac_result_t fail(logic [1:0] code);
            frac_result_t r;
            r = '0;
            r.den = 31'd1;
            r.err = code;
            return r;
        endfunction

        function frac_result_t reduce(longint n, longint d);
            frac_result_t r;
            longint unsigned a, b, t;
            a = (n < 0) ? -n : n;
            b = d;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            n = n / longint'(a);
            d = d / longint'(a);
            if (n < -64'sd2147483648 || n > 64'sd2147483647 || d > 64'sd2147483647)
                return fail(ERR_OVF);
            r = '0;
            r.num = n[31:0];
            r.den = d[30:0];
            r.err = ERR_NONE;
            return r;
        endfunction

        function frac_result_t predict(logic [3:0] cmd, logic signed [31:0] na32,
                                       logic signed [31:0] da32, logic signed [31:0] nb32,
                                       logic signed [31:0] db32);
            frac_result_t r;
            longint na, da, nb, db, n, d, l, rr;
            na = na32;
            da = da32;
            nb = nb32;
            db = db32;
            if (cmd > CMD_ABS) return fail(ERR_DEN);
            if (cmd == CMD_NORM) begin
                if (da == 0) return fail(ERR_DEN);
                if (da < 0) begin
                    na = -na;
                    da = -da;
                end
                return reduce(na, da);
            end
            if (da <= 0) return fail(ERR_DEN);
            if (cmd <= CMD_CMP && db <= 0) return fail(ERR_DEN);
            case (cmd)
                CMD_ADD: begin
                    n = na * db + nb * da;
                    d = da * db;
                end
                CMD_SUB: begin
                    n = na * db - nb * da;
                    d = da * db;
                end
                CMD_MUL: begin
                    n = na * nb;
                    d = da * db;
                end
                CMD_DIV: begin
                    if (nb == 0) return fail(ERR_DEN);
                    n = na * db;
                    d = da * nb;
                    if (d < 0) begin
                        n = -n;
                        d = -d;
                    end
                end
                CMD_CMP: begin
                    l = na * db;
                    rr = nb * da;
                    r = fail(ERR_NONE);
                    r.lt = l < rr;
                    r.eq = l == rr;
                    r.gt = l > rr;
                    return r;
                end
                CMD_NEG: begin
                    n = -na;
                    d = da;
                end
                CMD_INV: begin
                    if (na == 0) return fail(ERR_DEN);
                    n = da;
                    d = na;
                    if (d < 0) begin
                        n = -n;
                        d = -d;
                    end
                end
                default: begin
                    n = (na < 0) ? -na : na;
                    d = da;
                end
            endcase
            return reduce(n, d);
        endfunction

        function void note_request(logic [3:0] cmd, logic [127:0] data);
            pending.push_back(predict(cmd, data[31:0], data[63:32], data[95:64],
                                      data[127:96]));
        endfunction

        function void check_result(logic [71:0] data);
            frac_result_t want, got;
            got.num = data[31:0];
            got.den = data[62:32];
            got.lt  = data[63];
            got.eq  = data[64];
            got.gt  = data[65];
            got.err = data[67:66];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want || data[71:68] !== 4'b0) begin
                $display("%0t: mismatch expected num=%0d den=%0d flags=%b err=%0d",
                         $time, want.num, want.den, {want.lt, want.eq, want.gt}, want.err);
                $display("%0t:          actual num=%0d den=%0d flags=%b err=%0d pad=%b",
                         $time, got.num, got.den, {got.lt, got.eq, got.gt}, got.err,
                         data[71:68]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    frac_scoreboard sb;
    int sent;
    int op_count[16];
    bit stim_done = 1'b0;

    rational_arithmetic_unit_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 20);
            1: return -$urandom_range(1, 20);
            2: return 32'h7FFFFFFF - $urandom_range(0, 3);
            3: return 32'h80000000 + $urandom_range(0, 3);
            4: return $urandom_range(1, 1000) * (1 << $urandom_range(0, 10));
            5: return -($urandom_range(1, 5000));
            default: return $urandom();
        endcase
    endfunction

    function logic [31:0] pick_den();
        if ($urandom_range(0, 9) == 0) return pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 30);
            1: return 32'h7FFFFFFF - $urandom_range(0, 3);
            2: return $urandom_range(1, 5000) * (1 << $urandom_range(0, 8));
            default: return 32'($urandom_range(1, 32'h7FFFFFFF));
        endcase
    endfunction

    // one request, held until s_tready; a random gap may follow at the end of a burst
    task automatic send(logic [3:0] cmd, logic [31:0] na, logic [31:0] da,
                        logic [31:0] nb, logic [31:0] db);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {db, nb, da, na};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, {db, nb, da, na});
        op_count[cmd]++;
        sent++;
    endtask

    task automatic gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver: stretches of always-ready alternate with random stalls
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (($time / 4000) % 3 == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int burst, waitc;
        logic [3:0] c;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(CMD_NORM, 32'd6, -32'd4, 0, 0);
        send(CMD_NORM, 32'h80000000, 32'hFFFFFFFF, 0, 0);
        send(CMD_NORM, 32'd5, 32'd0, 0, 0);
        send(CMD_NORM, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(CMD_ADD, 32'h7FFFFFFF, 32'd1, 32'h7FFFFFFF, 32'd1);
        send(CMD_ADD, 32'd1, 32'd3, 32'd1, 32'd6);
        send(CMD_SUB, 32'h80000000, 32'd1, 32'd1, 32'd1);
        send(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd0);
        send(CMD_MUL, 32'h80000000, 32'd1, 32'h80000000, 32'd1);
        send(CMD_MUL, 32'd2, 32'd3, 32'd3, 32'd2);
        send(CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
        send(CMD_DIV, 32'd3, 32'd4, -32'd9, 32'd8);
        send(CMD_DIV, 32'h80000000, 32'd1, -32'd1, 32'd1);
        send(CMD_CMP, 32'd1, 32'd3, 32'd2, 32'd6);
        send(CMD_CMP, -32'd1, 32'd2, 32'd1, 32'd2);
        send(CMD_CMP, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'd1);
        send(CMD_CMP, 32'd1, -32'd2, 32'd1, 32'd2);
        send(CMD_NEG, 32'h80000000, 32'd1, 32'hFFFFFFFF, 32'h80000000);
        send(CMD_INV, 32'd0, 32'd5, 0, 0);
        send(CMD_INV, -32'd4, 32'd6, 0, 0);
        send(CMD_INV, 32'h80000000, 32'd1, 0, 0);
        send(CMD_ABS, 32'h80000000, 32'd3, 0, 0);
        send(CMD_ABS, -32'd7, 32'd0, 0, 0);
        send(4'd9, 32'd1, 32'd1, 32'd1, 32'd1);
        send(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        gap();

        while (sent < 1375) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                c = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
                send(c, pick_value(), (c == CMD_NORM) ? pick_value() : pick_den(),
                     pick_value(), pick_den());
            end
            if ($urandom_range(0, 2) != 0) gap();
        end
        s_tvalid <= 1'b0;

        waitc = 0;
        while (sb.pending.size() != 0 && waitc < 200000) begin
            @(posedge aclk);
            waitc++;
        end
        repeat (400) @(posedge aclk);
        $display("Sent %0d requests: norm %0d add %0d sub %0d mul %0d div %0d", sent,
                 op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
        $display("cmp %0d neg %0d inv %0d abs %0d; %0d results checked, %0d errors",
                 op_count[5], op_count[6], op_count[7], op_count[8], sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
